// ===== rtl/rtlh_pkg.sv =====
package rtlh_pkg;

	// Default sizes
	localparam int THREAD_SLOTS_DEF = 1024;
	localparam int BIN_COUNT_DEF    = 32;

	// Field widths
	localparam int ID_W       = 22;
	localparam int TS_W       = 64;
	localparam int GRP_W      = 11;
	localparam int BIN_W      = 5;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	// Time units and threshold width (a 64-bit delta against unit << bin)
	localparam int NS_PER_US = 1000;
	localparam int NS_PER_MS = 1000000;
	localparam int THR_W     = 84;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CGROUP_FILTER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_FILTER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SELECTED_PROC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_OFF_CPU  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MILLIS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_BY       = 3'd5;

	// Grouping codes
	localparam logic [1:0] GROUP_GLOBAL  = 2'd0;
	localparam logic [1:0] GROUP_PROCESS = 2'd1;
	localparam logic [1:0] GROUP_THREAD  = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [ID_W-1:0]  prev_process;
		logic [ID_W-1:0]  prev_thread;
		logic             prev_running;
		logic [ID_W-1:0]  next_process;
		logic [ID_W-1:0]  next_thread;
		logic [TS_W-1:0]  timestamp;
		logic             in_cgroup;
		logic [GRP_W-1:0] read_group;
		logic [BIN_W-1:0] read_bin;
	} in_item_t;

	typedef struct packed {
		logic             recorded;
		logic [BIN_W-1:0] bin_index;
		logic [GRP_W-1:0] group_index;
		logic             dropped;
		logic [CNT_W-1:0] read_count;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OP,
		ST_RDW,
		ST_SUB,
		ST_THR,
		ST_BIN,
		ST_INC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic op_exec;
		logic rd_capture;
		logic sub_en;
		logic thr_en;
		logic bin_en;
		logic inc_en;
		logic out_load;
		logic clr_en;
		logic phase;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic blocked;
		logic meas_go;
		logic meas_ok;
	} dp_status_t;

	// Lower bound in ns of bin b for the selected unit
	function automatic logic [THR_W-1:0] bin_threshold(input logic millis, input int b);
		logic [THR_W-1:0] unit;
		unit = millis ? THR_W'(NS_PER_MS) : THR_W'(NS_PER_US);
		return unit << b;
	endfunction

endpackage

// ===== rtl/rtlh_ram.sv =====
module rtlh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/rtlh_datapath.sv =====
module rtlh_datapath #(
	parameter int THREAD_SLOTS = rtlh_pkg::THREAD_SLOTS_DEF,
	parameter int BIN_COUNT    = rtlh_pkg::BIN_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rtlh_pkg::in_item_t                 in_data,
	input  logic                               cfg_we,
	input  logic [rtlh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtlh_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  rtlh_pkg::ctrl_cmd_t                cmd,
	output rtlh_pkg::dp_status_t               status,
	output rtlh_pkg::out_item_t                out_data
);
	import rtlh_pkg::*;

	localparam int TW  = $clog2(THREAD_SLOTS);
	localparam int HD  = (THREAD_SLOTS + 1) * BIN_COUNT;
	localparam int HAW = $clog2(HD);
	localparam int GW  = $clog2(THREAD_SLOTS + 1);
	localparam int BW  = $clog2(BIN_COUNT);
	localparam int SW  = TS_W + 1;

	// Configuration registers
	logic            cgroup_filter_q;
	logic            process_filter_q;
	logic [ID_W-1:0] selected_process_q;
	logic            count_off_cpu_q;
	logic            unit_millis_q;
	logic [1:0]      group_by_q;

	in_item_t         item_q;
	logic             hit_q;
	logic [BIN_W-1:0] bin_q;
	logic [GRP_W-1:0] grp_q;
	logic             drop_q;
	logic [CNT_W-1:0] count_q;
	logic             rok_q;
	logic             meas_ok_q;
	logic [HAW-1:0]   clr_cnt_q;
	out_item_t        out_q;

	logic [TS_W-1:0]      delta_s1;
	logic [GW-1:0]        grp_s1;
	logic [BIN_COUNT-1:0] ge_s2;
	logic [BW-1:0]        bin_s3;
	logic [HAW-1:0]       haddr_s3;

	logic [SW-1:0]    start_rdata;
	logic [CNT_W-1:0] hist_rdata;

	logic            op_is_save;
	logic [ID_W-1:0] op_proc;
	logic [ID_W-1:0] op_thr;
	logic            op_enabled;
	logic            op_go;
	logic            op_oor;
	logic            read_ok;
	logic [HAW-1:0]  read_addr;
	logic [HAW-1:0]  bin_addr;
	logic [BW-1:0]   bin_enc;
	logic [BIN_COUNT-1:0] ge;
	logic [TS_W:0]   diff;
	logic            sub_ok;
	logic            proc_oor;
	logic [GW-1:0]   grp_sel;

	logic           start_we;
	logic [TW-1:0]  start_waddr;
	logic [SW-1:0]  start_wdata;
	logic           start_re;
	logic           hist_we;
	logic [HAW-1:0] hist_waddr;
	logic [CNT_W-1:0] hist_wdata;
	logic           hist_re;
	logic [HAW-1:0] hist_raddr;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cgroup_filter_q    <= 1'b0;
			process_filter_q   <= 1'b0;
			selected_process_q <= '0;
			count_off_cpu_q    <= 1'b0;
			unit_millis_q      <= 1'b0;
			group_by_q         <= GROUP_GLOBAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CGROUP_FILTER:  cgroup_filter_q    <= cfg_data[0];
				REG_PROCESS_FILTER: process_filter_q   <= cfg_data[0];
				REG_SELECTED_PROC:  selected_process_q <= cfg_data[ID_W-1:0];
				REG_COUNT_OFF_CPU:  count_off_cpu_q    <= cfg_data[0];
				REG_UNIT_MILLIS:    unit_millis_q      <= cfg_data[0];
				REG_GROUP_BY:       group_by_q         <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Decode the current half of a switch event: first half uses the leaving thread
	always_comb begin
		op_is_save = count_off_cpu_q ? !cmd.phase : cmd.phase;
		op_proc    = cmd.phase ? item_q.next_process : item_q.prev_process;
		op_thr     = cmd.phase ? item_q.next_thread : item_q.prev_thread;
		op_enabled = op_is_save || count_off_cpu_q || item_q.prev_running;
		op_go      = op_enabled && (!process_filter_q || op_proc == selected_process_q);
		op_oor     = op_thr >= ID_W'(THREAD_SLOTS);
		read_ok    = (32'(item_q.read_group) <= 32'(THREAD_SLOTS))
			&& (32'(item_q.read_bin) < 32'(BIN_COUNT));
		read_addr  = HAW'(HAW'(item_q.read_group) * HAW'(BIN_COUNT)) + HAW'(item_q.read_bin);
	end

	// Elapsed time and group choice
	always_comb begin
		diff     = {1'b0, item_q.timestamp} - {1'b0, start_rdata[TS_W-1:0]};
		proc_oor = op_proc >= ID_W'(THREAD_SLOTS);
		sub_ok   = start_rdata[TS_W] && !diff[TS_W];
		case (group_by_q)
			GROUP_PROCESS: grp_sel = GW'(op_proc);
			GROUP_THREAD:  grp_sel = GW'(op_thr);
			default:       grp_sel = GW'(THREAD_SLOTS);
		endcase
	end

	// Compare the delta against the lower bound of every bin above bin 0
	always_comb begin
		ge[0] = 1'b0;
		for (int b = 1; b < BIN_COUNT; b++) begin
			ge[b] = {(THR_W - TS_W)'(0), delta_s1} >= bin_threshold(unit_millis_q, b);
		end
	end

	// Highest bound reached gives the bin; the top bin catches the rest
	always_comb begin
		bin_enc = '0;
		for (int b = 1; b < BIN_COUNT; b++) begin
			if (ge_s2[b]) begin
				bin_enc = BW'(b);
			end
		end
		bin_addr = HAW'(HAW'(grp_s1) * HAW'(BIN_COUNT)) + HAW'(bin_enc);
	end

	// Item and result flags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= in_data;
			hit_q   <= 1'b0;
			bin_q   <= '0;
			grp_q   <= '0;
			drop_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.op_exec) begin
				if (item_q.mode) begin
					rok_q <= read_ok;
					if (!read_ok) begin
						drop_q <= 1'b1;
					end
				end else if (op_go && op_oor) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.sub_en && sub_ok && group_by_q == GROUP_PROCESS && proc_oor) begin
				drop_q <= 1'b1;
			end
			if (cmd.rd_capture) begin
				count_q <= rok_q ? hist_rdata : '0;
			end
			if (cmd.inc_en) begin
				hit_q <= 1'b1;
				bin_q <= BIN_W'(bin_s3);
				grp_q <= GRP_W'(grp_s1);
			end
		end
	end

	// Measurement pipeline
	always_ff @(posedge clk) begin
		if (cmd.sub_en) begin
			delta_s1  <= diff[TS_W-1:0];
			grp_s1    <= grp_sel;
			meas_ok_q <= sub_ok && !(group_by_q == GROUP_PROCESS && proc_oor);
		end
		if (cmd.thr_en) begin
			ge_s2 <= ge;
		end
		if (cmd.bin_en) begin
			bin_s3   <= bin_enc;
			haddr_s3 <= bin_addr;
		end
	end

	// Clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.recorded    <= hit_q;
			out_q.bin_index   <= bin_q;
			out_q.group_index <= grp_q;
			out_q.dropped     <= drop_q;
			out_q.read_count  <= count_q;
		end
	end

	// Memory port steering
	always_comb begin
		start_we    = 1'b0;
		start_waddr = TW'(op_thr);
		start_wdata = {1'b1, item_q.timestamp};
		if (cmd.clr_en) begin
			start_we    = clr_cnt_q < HAW'(THREAD_SLOTS);
			start_waddr = clr_cnt_q[TW-1:0];
			start_wdata = '0;
		end else if (cmd.op_exec && !item_q.mode && op_go && !op_oor && op_is_save) begin
			start_we = 1'b1;
		end
		start_re = cmd.op_exec && !item_q.mode && op_go && !op_oor && !op_is_save;

		hist_we    = cmd.clr_en || cmd.inc_en;
		hist_waddr = cmd.clr_en ? clr_cnt_q : haddr_s3;
		hist_wdata = cmd.clr_en ? '0 : hist_rdata + 1'b1;
		hist_re    = cmd.bin_en || (cmd.op_exec && item_q.mode && read_ok);
		hist_raddr = item_q.mode ? read_addr : bin_addr;
	end

	rtlh_ram #(
		.WIDTH(SW),
		.DEPTH(THREAD_SLOTS)
	) u_start_ram (
		.clk   (clk),
		.we    (start_we),
		.waddr (start_waddr),
		.wdata (start_wdata),
		.re    (start_re),
		.raddr (TW'(op_thr)),
		.rdata (start_rdata)
	);

	rtlh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(HD)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	always_comb begin
		status.clr_last = clr_cnt_q == HAW'(HD - 1);
		status.is_read  = item_q.mode;
		status.blocked  = cgroup_filter_q && !item_q.in_cgroup;
		status.meas_go  = op_go && !op_oor && !op_is_save;
		status.meas_ok  = meas_ok_q;
	end

	assign out_data = out_q;
endmodule

// ===== rtl/rtlh_ctrl.sv =====
module rtlh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  rtlh_pkg::dp_status_t  status,
	output rtlh_pkg::ctrl_cmd_t   cmd
);
	import rtlh_pkg::*;

	state_t state_q, state_n;
	logic   ph_q, ph_n;
	logic   out_valid_q, out_valid_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			ph_q        <= ph_n;
			out_valid_q <= out_valid_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n     = state_q;
		ph_n        = ph_q;
		out_valid_n = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.phase   = ph_q;
		in_ready    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					ph_n     = 1'b0;
					state_n  = ST_OP;
				end
			end
			ST_OP: begin
				cmd.op_exec = !status.blocked || status.is_read;
				if (status.is_read) begin
					state_n = ST_RDW;
				end else if (status.blocked) begin
					state_n = ST_DONE;
				end else if (status.meas_go) begin
					state_n = ST_SUB;
				end else if (!ph_q) begin
					ph_n = 1'b1;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_RDW: begin
				cmd.rd_capture = 1'b1;
				state_n        = ST_DONE;
			end
			ST_SUB: begin
				cmd.sub_en = 1'b1;
				state_n    = ST_THR;
			end
			ST_THR: begin
				cmd.thr_en = 1'b1;
				if (status.meas_ok) begin
					state_n = ST_BIN;
				end else if (!ph_q) begin
					ph_n    = 1'b1;
					state_n = ST_OP;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_BIN: begin
				cmd.bin_en = 1'b1;
				state_n    = ST_INC;
			end
			ST_INC: begin
				cmd.inc_en = 1'b1;
				if (!ph_q) begin
					ph_n    = 1'b1;
					state_n = ST_OP;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hand over once the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_n  = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ===== rtl/run_time_log2_histogram_core.sv =====
// Steps: a read passes the op and read-capture states, a filtered event goes from op to done;
// only one half of an event can measure: a save half ends in the op state, a measure half runs
// through subtract and threshold, and on to bin and increment when the span counts. Items are
// taken one at a time; the start-table read and histogram read-modify-write use one-read-port memories.
// Reset: asynchronous, active low; afterwards a clearing pass over all
// (THREAD_SLOTS+1)*BIN_COUNT counters (32800 by default) zeroes counters and start flags.
module run_time_log2_histogram_core #(
	parameter int THREAD_SLOTS = rtlh_pkg::THREAD_SLOTS_DEF,
	parameter int BIN_COUNT    = rtlh_pkg::BIN_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rtlh_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rtlh_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [rtlh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtlh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtlh_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rtlh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rtlh_datapath #(
		.THREAD_SLOTS(THREAD_SLOTS),
		.BIN_COUNT   (BIN_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);
endmodule

// ===== rtl/rtlh_checker.sv =====
module rtlh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input rtlh_pkg::out_item_t             out_data
);
	import rtlh_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Take one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while one is at work");

	// A recorded bin never comes with a counter value
	a_rec_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.recorded |-> out_data.read_count == '0)
		else $error("recorded result carries a count");

	// Without a record the bin and group read zero
	a_norec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.recorded |->
			out_data.bin_index == '0 && out_data.group_index == '0)
		else $error("bin or group set without a record");
endmodule

bind run_time_log2_histogram_core rtlh_checker u_rtlh_checker (.*);

// ===== tb/run_time_log2_histogram_core_tb.sv =====
`timescale 1ns / 100ps

import rtlh_pkg::*;

// Shadow of the run-time histogram: start table, bin counters, registers
class histo_scoreboard;
	bit               cg_filter, proc_filter, off_cpu, millis;
	logic [ID_W-1:0]  sel_proc;
	logic [1:0]       grouping;
	logic [TS_W-1:0]  start_ts [1024];
	bit               start_ok [1024];
	logic [CNT_W-1:0] counts [32800];
	out_item_t        expected_q [$];
	int               errors;

	function new();
		foreach (start_ok[i]) start_ok[i] = 0;
		foreach (counts[i]) counts[i] = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_CGROUP_FILTER:  cg_filter = val[0];
			REG_PROCESS_FILTER: proc_filter = val[0];
			REG_SELECTED_PROC:  sel_proc = val[ID_W-1:0];
			REG_COUNT_OFF_CPU:  off_cpu = val[0];
			REG_UNIT_MILLIS:    millis = val[0];
			REG_GROUP_BY:       grouping = val[1:0];
			default: ;
		endcase
	endfunction

	function bit proc_ok(logic [ID_W-1:0] p);
		return !proc_filter || p == sel_proc;
	endfunction

	function void record_start(logic [ID_W-1:0] p, logic [ID_W-1:0] t,
			logic [TS_W-1:0] ts, ref out_item_t r);
		if (!proc_ok(p)) return;
		if (t >= 1024) begin
			r.dropped = 1'b1;
			return;
		end
		start_ts[t] = ts;
		start_ok[t] = 1;
	endfunction

	function void measure_span(logic [ID_W-1:0] p, logic [ID_W-1:0] t,
			logic [TS_W-1:0] ts, ref out_item_t r);
		int grp, b;
		logic [TS_W-1:0] span;
		if (!proc_ok(p)) return;
		if (t >= 1024) begin
			r.dropped = 1'b1;
			return;
		end
		if (!start_ok[t] || ts < start_ts[t]) return;
		if (grouping == GROUP_PROCESS) begin
			if (p >= 1024) begin
				r.dropped = 1'b1;
				return;
			end
			grp = p;
		end else if (grouping == GROUP_THREAD) begin
			grp = t;
		end else begin
			grp = 1024;
		end
		span = (ts - start_ts[t]) / (millis ? 64'd1000000 : 64'd1000);
		b = 0;
		while (span > 1) begin
			span >>= 1;
			b++;
		end
		if (b > 31) b = 31;
		counts[grp*32 + b] += 1;
		r.recorded = 1'b1;
		r.bin_index = BIN_W'(b);
		r.group_index = GRP_W'(grp);
	endfunction

	// Note an accepted input transfer and queue its outcome
	function void note_input(in_item_t it);
		out_item_t r;
		r = '0;
		if (it.mode) begin
			if (it.read_group <= 1024) r.read_count = counts[it.read_group*32 + it.read_bin];
			else r.dropped = 1'b1;
		end else if (!cg_filter || it.in_cgroup) begin
			if (off_cpu) begin
				record_start(it.prev_process, it.prev_thread, it.timestamp, r);
				measure_span(it.next_process, it.next_thread, it.timestamp, r);
			end else begin
				if (it.prev_running)
					measure_span(it.prev_process, it.prev_thread, it.timestamp, r);
				record_start(it.next_process, it.next_thread, it.timestamp, r);
			end
		end
		expected_q.push_back(r);
	endfunction

	// Compare a result transfer with the oldest outcome
	function void check_result(out_item_t got);
		out_item_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (got.recorded !== e.recorded || got.bin_index !== e.bin_index ||
				got.group_index !== e.group_index || got.dropped !== e.dropped ||
				got.read_count !== e.read_count) begin
			$display("%0t: mismatch expected %p actual %p", $time, e, got);
			errors++;
		end
	endfunction
endclass

module run_time_log2_histogram_core_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	in_item_t in_data = '0;
	logic out_valid, out_ready = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	histo_scoreboard sb = new();
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [TS_W-1:0] ts_now = 64'd5000;
	logic [ID_W-1:0] proc_pool [4];

	always #4 clk = ~clk;

	run_time_log2_histogram_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Sample transfers and run the watchdog
	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_input(in_data);
		if (out_valid && out_ready) sb.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= 200000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 0;
		end else begin
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send(in_item_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic configure(bit cg, bit pf, logic [ID_W-1:0] sp, bit off, bit ms,
			logic [1:0] grp);
		write_reg(REG_CGROUP_FILTER, CFG_DATA_W'(cg));
		write_reg(REG_PROCESS_FILTER, CFG_DATA_W'(pf));
		write_reg(REG_SELECTED_PROC, CFG_DATA_W'(sp));
		write_reg(REG_COUNT_OFF_CPU, CFG_DATA_W'(off));
		write_reg(REG_UNIT_MILLIS, CFG_DATA_W'(ms));
		write_reg(REG_GROUP_BY, CFG_DATA_W'(grp));
		proc_pool[3] = sp;
	endtask

	function automatic in_item_t switch_ev(logic [ID_W-1:0] pp, logic [ID_W-1:0] pt, bit run,
			logic [ID_W-1:0] np, logic [ID_W-1:0] nt, logic [TS_W-1:0] ts, bit cg);
		in_item_t it;
		it = '0;
		it.prev_process = pp;
		it.prev_thread = pt;
		it.prev_running = run;
		it.next_process = np;
		it.next_thread = nt;
		it.timestamp = ts;
		it.in_cgroup = cg;
		return it;
	endfunction

	function automatic in_item_t read_req(logic [GRP_W-1:0] g, logic [BIN_W-1:0] b);
		in_item_t it;
		it = '0;
		it.mode = 1;
		it.read_group = g;
		it.read_bin = b;
		return it;
	endfunction

	function automatic logic [ID_W-1:0] pick_thread();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return ID_W'($urandom_range(1024, 4194303));
		if (r < 15) return ID_W'($urandom_range(1016, 1023));
		return ID_W'($urandom_range(0, 7));
	endfunction

	function automatic logic [ID_W-1:0] pick_proc();
		if ($urandom_range(0, 99) < 6) return ID_W'($urandom);
		return proc_pool[$urandom_range(0, 3)];
	endfunction

	// Read requests and switch events; time mostly moves forward with spans of every magnitude, some jumps back
	function automatic in_item_t random_item();
		in_item_t it;
		int r;
		it = '0;
		it.read_group = GRP_W'($urandom);
		it.read_bin = BIN_W'($urandom);
		if ($urandom_range(0, 99) < 15) begin
			it.mode = 1;
			if ($urandom_range(0, 9) == 0) it.read_group = GRP_W'($urandom_range(1025, 2047));
			else if ($urandom_range(0, 2) == 0) it.read_group = GRP_W'(1024);
			else it.read_group = GRP_W'($urandom_range(0, 1023));
			return it;
		end
		r = $urandom_range(0, 99);
		if (r < 4) ts_now = {$urandom, $urandom};
		else if (r < 9) ts_now = ts_now - ({$urandom, $urandom} >> $urandom_range(20, 63));
		else ts_now = ts_now + ({$urandom, $urandom} >> $urandom_range(0, 63));
		return switch_ev(pick_proc(), pick_thread(), $urandom_range(0, 9) < 8,
			pick_proc(), pick_thread(), ts_now, $urandom_range(0, 99) < 85);
	endfunction

	task automatic run_phase(int n);
		repeat (n) send(random_item());
		drain();
	endtask

	initial begin
		proc_pool[0] = 3;
		proc_pool[1] = 5;
		proc_pool[2] = 1023;
		proc_pool[3] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		configure(0, 0, 0, 0, 0, GROUP_GLOBAL);
		send_idle_pct = 6;
		recv_idle_pct = 47;

		// Directed: id extremes, time extremes, backwards time, reads out of range
		send(switch_ev(0, 0, 1, 0, 0, 64'd0, 1));
		send(switch_ev(0, 0, 1, 0, 1023, 64'd0, 0));
		send(switch_ev(0, 0, 1, 1023, 1, 64'd999, 1));
		send(switch_ev(0, 1023, 1, 4194303, 4194303, 64'd1000, 1));
		send(switch_ev(0, 1, 1, 4194303, 1024, 64'd2000, 1));
		send(switch_ev(0, 0, 1, 0, 0, 64'd1500, 1));
		send(switch_ev(0, 0, 0, 0, 2, '1, 1));
		send(switch_ev(0, 2, 1, 0, 2, '1, 1));
		send(switch_ev(0, 2, 1, 0, 3, 64'd10, 1));
		send(switch_ev(4194303, 4194303, 1, 4194303, 4194303, 64'd20, 1));
		send(read_req(1024, 0));
		send(read_req(1024, 31));
		send(read_req(0, 0));
		send(read_req(1025, 5));
		send(read_req(2047, 31));
		drain();
		configure(1, 1, 4194303, 1, 1, 2'd3);
		send(switch_ev(4194303, 4, 1, 4194303, 5, 64'd0, 0));
		send(switch_ev(4194303, 4, 1, 4194303, 5, 64'd0, 1));
		send(switch_ev(4194303, 5, 1, 4194303, 4, '1, 1));
		send(switch_ev(7, 6, 1, 4194303, 1024, 64'd5, 1));
		send(read_req(1024, 31));
		drain();

		configure(0, 0, 0, 0, 0, GROUP_GLOBAL);
		run_phase(300);
		configure(0, 0, 0, 1, 0, GROUP_THREAD);
		run_phase(300);
		send_idle_pct = 47;
		recv_idle_pct = 6;
		configure(1, 1, 5, 0, 1, GROUP_PROCESS);
		run_phase(300);
		configure(0, 1, 4194303, 1, 1, 2'd3);
		run_phase(300);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(0, 0, 0, 0, 0, GROUP_PROCESS);
		hold_req = 1;
		run_phase(300);
		configure(1, 0, 1023, 1, 0, GROUP_THREAD);
		run_phase(300);

		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/rtlh_pkg.sv
rtl/rtlh_ram.sv
rtl/rtlh_datapath.sv
rtl/rtlh_ctrl.sv
rtl/run_time_log2_histogram_core.sv
rtl/rtlh_checker.sv
tb/run_time_log2_histogram_core_tb.sv
